// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms used by the spot_checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is held.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/spot_pkg.sv -----
// ---------------------------------------------------------------------------
// spot_pkg
// Types, widths and pair-kind codes of the shape pair overlap test.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package spot_pkg;

    localparam int CoordW = 24;
    localparam int SizeW  = 23;
    localparam int ModeW  = 2;
    localparam int OperW  = 25;
    localparam int ProdW  = 2 * OperW;
    localparam int DataInW  = 240;
    localparam int DataOutW = 8;

    // Pair kinds.
    localparam logic [ModeW-1:0] MODE_RECT_RECT = 2'd0;
    localparam logic [ModeW-1:0] MODE_CIRC_CIRC = 2'd1;
    localparam logic [ModeW-1:0] MODE_RECT_CIRC = 2'd2;
    localparam logic [ModeW-1:0] MODE_CIRC_RECT = 2'd3;

    typedef struct packed {
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
        logic [SizeW-1:0]  w;
        logic [SizeW-1:0]  h;
        logic [SizeW-1:0]  r;
    } t_shape;

    typedef struct packed {
        logic [ModeW-1:0] mode;
        t_shape           a;
        t_shape           b;
    } t_item;

    // First stage: raw differences.
    typedef struct packed {
        logic [ModeW-1:0]  mode;
        logic              rr_hit;
        logic [CoordW:0]   cdx;
        logic [CoordW:0]   cdy;
        logic [CoordW-1:0] crs;
        logic [CoordW+2:0] dx;
        logic [CoordW+2:0] dy;
        logic [SizeW-1:0]  pw;
        logic [SizeW-1:0]  ph;
        logic [CoordW-1:0] rr;
    } t_delta;

    // Second stage: early decision or square operands.
    typedef struct packed {
        logic             decided;
        logic             hit;
        logic [OperW-1:0] u;
        logic [OperW-1:0] v;
        logic [OperW-1:0] s;
    } t_oper;

    // Third stage: squares.
    typedef struct packed {
        logic             decided;
        logic             hit;
        logic [ProdW-1:0] uu;
        logic [ProdW-1:0] vv;
        logic [ProdW-1:0] ss;
    } t_prod;

    // Coordinate sign-extended to 26 bits.
    function automatic logic signed [CoordW+1:0] coord_ext(logic [CoordW-1:0] c);
        return $signed({{2{c[CoordW-1]}}, c});
    endfunction

    // Far edge of a rectangle along one axis, 26 bits signed.
    function automatic logic signed [CoordW+1:0] far_edge(logic [CoordW-1:0] c,
                                                          logic [SizeW-1:0] s);
        return $signed({{2{c[CoordW-1]}}, c}) + $signed({3'b000, s});
    endfunction

    // Doubled centre offset: 2*corner + size - 2*centre, 27 bits signed.
    function automatic logic signed [CoordW+2:0] dbl_offset(logic [CoordW-1:0] p,
                                                            logic [SizeW-1:0] s,
                                                            logic [CoordW-1:0] c);
        return $signed({{2{p[CoordW-1]}}, p, 1'b0}) + $signed({4'b0000, s})
             - $signed({{2{c[CoordW-1]}}, c, 1'b0});
    endfunction

endpackage

// ----- rtl/core/shape_pair_overlap_test.sv -----
// ---------------------------------------------------------------------------
// shape_pair_overlap_test
// Streams pairs of rectangles and circles in, one overlap flag per pair out.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  s_axis    in         tuser: mode; tdata: a_x a_y a_w a_h a_r b_x b_y b_w b_h b_r
//  m_axis    out        tdata: overlap in bit 0
//
// One pair is taken in every cycle and one result leaves in every cycle while m_axis is not stalled.
// A result passes through the input register, the difference stage, the
// select stage, the squarer stage and the result register before it
// appears on m_axis.
// Reset is synchronous and active low; it empties every stage.
// A stall on m_axis holds the result; inner stages keep filling until the
// pipeline is full, and only then does s_axis deassert tready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module shape_pair_overlap_test (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // mode[1:0]
    input  logic [spot_pkg::ModeW-1:0]    i_s_axis_tuser,
    // a_x[23:0], a_y[47:24], a_w[70:48], a_h[93:71], a_r[116:94],
    // b_x[140:117], b_y[164:141], b_w[187:165], b_h[210:188], b_r[233:211],
    // zero padding [239:234]
    input  logic [spot_pkg::DataInW-1:0]  i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // overlap[0], zero padding [7:1]
    output logic [spot_pkg::DataOutW-1:0] o_m_axis_tdata
);
    import spot_pkg::*;

    // Stage valid bits: input register, delta, select, square, result.
    localparam int Stages = 5;

    logic [Stages-1:0] r_vld;
    logic [Stages-1:0] n_vld;
    logic [Stages-1:0] w_adv;

    t_item  n_item;
    t_item  r_item;
    t_delta w_delta;
    t_oper  w_oper;
    t_prod  w_prod;
    logic   w_overlap;

    // A stage may load whenever it is empty or the stage after it moves on.
    always_comb begin
        w_adv[4] = !r_vld[4] || i_m_axis_tready;
        w_adv[3] = !r_vld[3] || w_adv[4];
        w_adv[2] = !r_vld[2] || w_adv[3];
        w_adv[1] = !r_vld[1] || w_adv[2];
        w_adv[0] = !r_vld[0] || w_adv[1];
    end

    always_comb begin
        n_vld[0] = w_adv[0] ? i_s_axis_tvalid : r_vld[0];
        n_vld[1] = w_adv[1] ? r_vld[0] : r_vld[1];
        n_vld[2] = w_adv[2] ? r_vld[1] : r_vld[2];
        n_vld[3] = w_adv[3] ? r_vld[2] : r_vld[3];
        n_vld[4] = w_adv[4] ? r_vld[3] : r_vld[4];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Unpack the incoming transaction into the input register.
    always_comb begin
        n_item.mode = i_s_axis_tuser;
        n_item.a.x  = i_s_axis_tdata[23:0];
        n_item.a.y  = i_s_axis_tdata[47:24];
        n_item.a.w  = i_s_axis_tdata[70:48];
        n_item.a.h  = i_s_axis_tdata[93:71];
        n_item.a.r  = i_s_axis_tdata[116:94];
        n_item.b.x  = i_s_axis_tdata[140:117];
        n_item.b.y  = i_s_axis_tdata[164:141];
        n_item.b.w  = i_s_axis_tdata[187:165];
        n_item.b.h  = i_s_axis_tdata[210:188];
        n_item.b.r  = i_s_axis_tdata[233:211];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_item <= n_item;
        end
    end

    // Edge compares for rect-rect and centre offsets for the round pairs.
    spot_delta u_delta (
        .i_clk   (i_clk),
        .i_en    (w_adv[1]),
        .i_item  (r_item),
        .o_delta (w_delta)
    );

    // Resolve the easy cases and pick the operands of the squarers.
    spot_select u_select (
        .i_clk   (i_clk),
        .i_en    (w_adv[2]),
        .i_delta (w_delta),
        .o_oper  (w_oper)
    );

    spot_square u_square (
        .i_clk  (i_clk),
        .i_en   (w_adv[3]),
        .i_oper (w_oper),
        .o_prod (w_prod)
    );

    // The result register doubles as the output register of m_axis.
    spot_decide u_decide (
        .i_clk     (i_clk),
        .i_en      (w_adv[4]),
        .i_prod    (w_prod),
        .o_overlap (w_overlap)
    );

    assign o_s_axis_tready = w_adv[0];
    assign o_m_axis_tvalid = r_vld[4];
    assign o_m_axis_tdata  = {{(DataOutW-1){1'b0}}, w_overlap};

endmodule

// ----- rtl/core/spot_delta.sv -----
// ---------------------------------------------------------------------------
// spot_delta
// First stage: rectangle edge compares and centre differences.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module spot_delta (
    input  logic            i_clk,
    input  logic            i_en,
    input  spot_pkg::t_item i_item,
    output spot_pkg::t_delta o_delta
);
    import spot_pkg::*;

    t_delta n_delta;
    t_delta r_delta;
    t_shape w_rect;
    t_shape w_circ;

    always_comb begin
        // In circle-rect pairs the rectangle is the second shape.
        if (i_item.mode == MODE_CIRC_RECT) begin
            w_rect = i_item.b;
            w_circ = i_item.a;
        end else begin
            w_rect = i_item.a;
            w_circ = i_item.b;
        end

        n_delta.mode   = i_item.mode;
        n_delta.rr_hit = (coord_ext(i_item.a.x) <= far_edge(i_item.b.x, i_item.b.w)) &&
                         (far_edge(i_item.a.x, i_item.a.w) >= coord_ext(i_item.b.x)) &&
                         (coord_ext(i_item.a.y) <= far_edge(i_item.b.y, i_item.b.h)) &&
                         (far_edge(i_item.a.y, i_item.a.h) >= coord_ext(i_item.b.y));
        n_delta.cdx = {i_item.a.x[CoordW-1], i_item.a.x} - {i_item.b.x[CoordW-1], i_item.b.x};
        n_delta.cdy = {i_item.a.y[CoordW-1], i_item.a.y} - {i_item.b.y[CoordW-1], i_item.b.y};
        n_delta.crs = {1'b0, i_item.a.r} + {1'b0, i_item.b.r};
        n_delta.dx  = dbl_offset(w_rect.x, w_rect.w, w_circ.x);
        n_delta.dy  = dbl_offset(w_rect.y, w_rect.h, w_circ.y);
        n_delta.pw  = w_rect.w;
        n_delta.ph  = w_rect.h;
        n_delta.rr  = {w_circ.r, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_delta <= n_delta;
        end
    end

    assign o_delta = r_delta;

endmodule

// ----- rtl/core/spot_select.sv -----
// ---------------------------------------------------------------------------
// spot_select
// Second stage: magnitudes, early decisions and square operands.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module spot_select (
    input  logic             i_clk,
    input  logic             i_en,
    input  spot_pkg::t_delta i_delta,
    output spot_pkg::t_oper  o_oper
);
    import spot_pkg::*;

    t_oper             n_oper;
    t_oper             r_oper;
    logic [OperW-1:0]  w_cu;
    logic [OperW-1:0]  w_cv;
    logic [CoordW+1:0] w_adx;
    logic [CoordW+1:0] w_ady;
    logic [OperW-1:0]  w_xlim;
    logic [OperW-1:0]  w_ylim;
    logic              w_far;
    logic              w_near;

    always_comb begin
        w_cu   = i_delta.cdx[CoordW] ? OperW'(-i_delta.cdx) : i_delta.cdx;
        w_cv   = i_delta.cdy[CoordW] ? OperW'(-i_delta.cdy) : i_delta.cdy;
        w_adx  = i_delta.dx[CoordW+2] ? (CoordW+2)'(-i_delta.dx) : i_delta.dx[CoordW+1:0];
        w_ady  = i_delta.dy[CoordW+2] ? (CoordW+2)'(-i_delta.dy) : i_delta.dy[CoordW+1:0];
        w_xlim = {2'b00, i_delta.pw} + {1'b0, i_delta.rr};
        w_ylim = {2'b00, i_delta.ph} + {1'b0, i_delta.rr};
        w_far  = (w_adx > {1'b0, w_xlim}) || (w_ady > {1'b0, w_ylim});
        w_near = (w_adx <= {3'b000, i_delta.pw}) || (w_ady <= {3'b000, i_delta.ph});

        n_oper.decided = 1'b0;
        n_oper.hit     = 1'b0;
        n_oper.u       = '0;
        n_oper.v       = '0;
        n_oper.s       = '0;
        case (i_delta.mode)
            MODE_RECT_RECT: begin
                n_oper.decided = 1'b1;
                n_oper.hit     = i_delta.rr_hit;
            end
            MODE_CIRC_CIRC: begin
                n_oper.u = w_cu;
                n_oper.v = w_cv;
                n_oper.s = {1'b0, i_delta.crs};
            end
            default: begin
                // Rectangle against circle; only the corner region needs squares.
                if (w_far) begin
                    n_oper.decided = 1'b1;
                end else if (w_near) begin
                    n_oper.decided = 1'b1;
                    n_oper.hit     = 1'b1;
                end else begin
                    n_oper.u = OperW'(w_adx - {3'b000, i_delta.pw});
                    n_oper.v = OperW'(w_ady - {3'b000, i_delta.ph});
                    n_oper.s = {1'b0, i_delta.rr};
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_oper <= n_oper;
        end
    end

    assign o_oper = r_oper;

endmodule

// ----- rtl/core/spot_square.sv -----
// ---------------------------------------------------------------------------
// spot_square
// Third stage: three parallel 25 by 25 bit squarers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module spot_square (
    input  logic            i_clk,
    input  logic            i_en,
    input  spot_pkg::t_oper i_oper,
    output spot_pkg::t_prod o_prod
);
    import spot_pkg::*;

    t_prod n_prod;
    t_prod r_prod;

    always_comb begin
        n_prod.decided = i_oper.decided;
        n_prod.hit     = i_oper.hit;
        n_prod.uu      = {{OperW{1'b0}}, i_oper.u} * {{OperW{1'b0}}, i_oper.u};
        n_prod.vv      = {{OperW{1'b0}}, i_oper.v} * {{OperW{1'b0}}, i_oper.v};
        n_prod.ss      = {{OperW{1'b0}}, i_oper.s} * {{OperW{1'b0}}, i_oper.s};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

// ----- rtl/core/spot_decide.sv -----
// ---------------------------------------------------------------------------
// spot_decide
// Last stage: sum of squares against the radius square, result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module spot_decide (
    input  logic            i_clk,
    input  logic            i_en,
    input  spot_pkg::t_prod i_prod,
    output logic            o_overlap
);
    import spot_pkg::*;

    logic [ProdW:0] w_sum;
    logic           n_overlap;
    logic           r_overlap;

    always_comb begin
        w_sum = {1'b0, i_prod.uu} + {1'b0, i_prod.vv};
        n_overlap = i_prod.decided ? i_prod.hit : (w_sum <= {1'b0, i_prod.ss});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_overlap <= n_overlap;
        end
    end

    assign o_overlap = r_overlap;

endmodule

// ----- rtl/core/spot_checker.sv -----
// ---------------------------------------------------------------------------
// spot_checker
// Port-level assertions for the shape pair overlap test.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spot_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_axis_tvalid,
    input logic                          i_s_axis_tready,
    input logic [spot_pkg::ModeW-1:0]    i_s_axis_tuser,
    input logic [spot_pkg::DataInW-1:0]  i_s_axis_tdata,
    input logic                          i_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [spot_pkg::DataOutW-1:0] i_m_axis_tdata
);
    // A result that waits stays put.
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, i_m_axis_tvalid && !i_m_axis_tready |=> i_m_axis_tvalid && $stable(i_m_axis_tdata), "stalled result changed or vanished")

    // A pair that waits for the block stays offered and unchanged.
    `ASSERT_CLK(a_in_hold, i_clk, i_rst_n, i_s_axis_tvalid && !i_s_axis_tready |=> i_s_axis_tvalid && $stable({i_s_axis_tuser, i_s_axis_tdata}), "waiting input changed or withdrawn")

    // Reset empties the pipeline.
    `ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !i_m_axis_tvalid, "result shown right after reset")

    // With nothing waiting at the output the input side is always open.
    `ASSERT_CLK(a_open_when_empty, i_clk, i_rst_n, !i_m_axis_tvalid |-> i_s_axis_tready, "input refused while output is empty")

    // A full, stalled pipeline stays closed until the output moves.
    `ASSERT_CLK(a_full_stays_closed, i_clk, i_rst_n, i_m_axis_tvalid && !i_m_axis_tready && !i_s_axis_tready |=> !i_s_axis_tready || i_m_axis_tready, "input opened while output stalled")

endmodule

bind shape_pair_overlap_test spot_checker u_spot_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .i_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata)
);

// ----- tb/overlap_checker.sv -----
// ---------------------------------------------------------------------------
// Overlap checker
// Watches both stream channels of the shape pair overlap test, predicts the
// overlap flag of every accepted pair and compares it with the result stream.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module overlap_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [spot_pkg::ModeW-1:0]    i_in_mode,
    input  logic [spot_pkg::DataInW-1:0]  i_in_data,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [spot_pkg::DataOutW-1:0] i_out_data,
    output int                            o_fail_count,
    output int                            o_pending
);

    import spot_pkg::*;

    localparam int     ShapeW     = 2 * CoordW + 3 * SizeW;
    localparam longint Doubling   = 2;
    localparam int     MaxReports = 50;

    typedef struct {
        longint x;
        longint y;
        longint w;
        longint h;
        longint r;
    } t_geom;

    typedef struct packed {
        logic [ModeW-1:0] mode;
        logic             overlap;
    } t_verdict;

    t_verdict verdict_q[$];
    int       fail_total = 0;

    function automatic t_geom unpack_shape(logic [ShapeW-1:0] f);
        t_geom g;
        g.x = longint'($signed(f[0 +: CoordW]));
        g.y = longint'($signed(f[CoordW +: CoordW]));
        g.w = longint'(f[2 * CoordW +: SizeW]);
        g.h = longint'(f[2 * CoordW + SizeW +: SizeW]);
        g.r = longint'(f[2 * CoordW + 2 * SizeW +: SizeW]);
        return g;
    endfunction

    // Rectangle against circle in doubled units, so the rectangle centre is exact.
    function automatic logic rect_circle_touch(t_geom rc, t_geom ci);
        longint dx;
        longint dy;
        longint rr;
        longint ex;
        longint ey;
        dx = Doubling * rc.x + rc.w - Doubling * ci.x;
        dy = Doubling * rc.y + rc.h - Doubling * ci.y;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        rr = Doubling * ci.r;
        if (dx > rc.w + rr || dy > rc.h + rr) return 1'b0;
        if (dx <= rc.w || dy <= rc.h) return 1'b1;
        ex = dx - rc.w;
        ey = dy - rc.h;
        return (ex * ex + ey * ey <= rr * rr);
    endfunction

    function automatic logic predict_overlap(logic [ModeW-1:0] mode,
                                             logic [DataInW-1:0] d);
        t_geom  a;
        t_geom  b;
        longint dx;
        longint dy;
        longint rs;
        logic   hit;
        a = unpack_shape(d[0 +: ShapeW]);
        b = unpack_shape(d[ShapeW +: ShapeW]);
        case (mode)
            MODE_RECT_RECT: begin
                hit = (a.x <= b.x + b.w) && (a.x + a.w >= b.x) &&
                      (a.y <= b.y + b.h) && (a.y + a.h >= b.y);
            end
            MODE_CIRC_CIRC: begin
                dx  = a.x - b.x;
                dy  = a.y - b.y;
                rs  = a.r + b.r;
                hit = (dx * dx + dy * dy <= rs * rs);
            end
            MODE_RECT_CIRC: begin
                hit = rect_circle_touch(a, b);
            end
            default: begin
                hit = rect_circle_touch(b, a);
            end
        endcase
        return hit;
    endfunction

    task automatic log_failure(input string what);
        fail_total++;
        if (fail_total <= MaxReports) $display("%0t ns: %s", $time, what);
    endtask

    always @(posedge i_clk) begin
        t_verdict head;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (verdict_q.size() == 0) begin
                    log_failure($sformatf("unexpected result: expected none, actual %0b",
                                          i_out_data[0]));
                end else begin
                    head = verdict_q.pop_front();
                    if (i_out_data[0] !== head.overlap) begin
                        log_failure($sformatf("overlap mismatch (mode %0d): expected %0b, actual %0b",
                                              head.mode, head.overlap, i_out_data[0]));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                head.mode    = i_in_mode;
                head.overlap = predict_overlap(i_in_mode, i_in_data);
                verdict_q.push_back(head);
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= verdict_q.size();
    end

endmodule

// ----- tb/tb_top.sv -----
// ---------------------------------------------------------------------------
// Shape pair overlap test bench
// Drives directed and random shape pairs through the block with bursty input
// and a stalling output, and reports the verdict of the overlap checker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import spot_pkg::*;

    // Field extremes in raw Q15.8 units.
    localparam logic [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};
    localparam logic [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};
    localparam logic [SizeW-1:0]  SizeMax  = {SizeW{1'b1}};
    localparam int PadW        = DataInW - 2 * (2 * CoordW + 3 * SizeW);
    localparam int RandomItems = 1330;
    // The long hold-off on the result side starts once this many pairs went in.
    localparam int HoldOffAt   = 400;
    localparam int HoldOffLen  = 300;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [ModeW-1:0]     s_tuser;
    logic [DataInW-1:0]   s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [DataOutW-1:0]  m_tdata;

    int fail_count;
    int pending;
    int items_sent = 0;
    int burst_left = 0;

    shape_pair_overlap_test uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    // The checker sees the same handshakes as the block and owns all prediction.
    overlap_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (s_tvalid),
        .i_in_ready   (s_tready),
        .i_in_mode    (s_tuser),
        .i_in_data    (s_tdata),
        .i_out_valid  (m_tvalid),
        .i_out_ready  (m_tready),
        .i_out_data   (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on the run, far above the slowest legal schedule.
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Offers one pair and holds it until the block takes the transaction. The
    // inputs change on the falling edge only; tready is read at the rising
    // edge, which is where the transaction happens. After acceptance the
    // sender either continues its burst (tvalid stays high) or goes idle for
    // a random gap and then picks a new burst length.
    task automatic offer_pair(input logic [ModeW-1:0]  mode,
                              input logic [CoordW-1:0] ax, input logic [CoordW-1:0] ay,
                              input logic [SizeW-1:0]  aw, input logic [SizeW-1:0]  ah,
                              input logic [SizeW-1:0]  ar,
                              input logic [CoordW-1:0] bx, input logic [CoordW-1:0] by,
                              input logic [SizeW-1:0]  bw, input logic [SizeW-1:0]  bh,
                              input logic [SizeW-1:0]  br);
        int gap;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        // Shape a sits in the low bits, x first; the top bits are padding.
        s_tdata  <= {{PadW{1'b0}}, br, bh, bw, by, bx, ar, ah, aw, ay, ax};
        do @(posedge clk); while (s_tready !== 1'b1);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge clk) s_tvalid <= 1'b0;
            // Now and then a long burst, so that stretches without idling occur.
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 120)
                                                     : $urandom_range(0, 12);
        end
    endtask

    function automatic int jitter(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Result side: a pattern of its own, made of runs that are always ready,
    // runs that toggle at random and short runs that stall. Once, after enough
    // pairs have gone in, it holds off for a long stretch so that the pipeline
    // fills up and the block has to drop tready on its input.
    initial begin
        int span;
        int style;
        bit held_off;
        held_off = 1'b0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            if (!held_off && items_sent >= HoldOffAt) begin
                held_off = 1'b1;
                repeat (HoldOffLen) @(negedge clk) m_tready <= 1'b0;
            end
            style = $urandom_range(0, 9);
            span  = $urandom_range(1, 30);
            repeat (span) @(negedge clk) begin
                if (style < 4) begin
                    m_tready <= 1'b1;
                end else if (style < 8) begin
                    m_tready <= 1'($urandom_range(0, 1));
                end else begin
                    m_tready <= 1'b0;
                end
            end
        end
    end

    initial begin
        logic [ModeW-1:0]  mode;
        logic [CoordW-1:0] ax, ay, bx, by, base_x, base_y;
        logic [SizeW-1:0]  aw, ah, ar, bw, bh, br;
        int                span;

        s_tvalid = 1'b0;
        s_tuser  = '0;
        s_tdata  = '0;
        rst_n    = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Directed pairs. Argument order: mode, then x, y, w, h, r of shape a
        // and of shape b.
        // Rectangles: clear overlap, shared edge, one unit apart, gap on the left.
        offer_pair(MODE_RECT_RECT, 0, 0, 512, 512, 0, 256, 256, 512, 512, 0);
        offer_pair(MODE_RECT_RECT, 0, 0, 256, 256, 0, 256, 100, 10, 10, 0);
        offer_pair(MODE_RECT_RECT, 0, 0, 256, 256, 0, 257, 100, 10, 10, 0);
        offer_pair(MODE_RECT_RECT, 0, 0, 256, 256, 0, -20, 0, 19, 5, 0);
        // Two zero-size rectangles on one point; the radius field is unused.
        offer_pair(MODE_RECT_RECT, 5, 5, 0, 0, SizeMax, 5, 5, 0, 0, SizeMax);
        // Extreme corners and sizes, apart and touching.
        offer_pair(MODE_RECT_RECT, CoordMin, CoordMin, SizeMax, SizeMax, 0,
                   CoordMax, CoordMax, SizeMax, SizeMax, 0);
        offer_pair(MODE_RECT_RECT, CoordMin, CoordMin, SizeMax, SizeMax, 0,
                   -1, -1, 0, 0, 0);
        // Circles: exact touch with unused sizes at maximum, one unit short,
        // zero radii on one centre, far extremes, and touching at full span.
        offer_pair(MODE_CIRC_CIRC, 0, 0, SizeMax, SizeMax, 2, 3, 4, SizeMax, SizeMax, 3);
        offer_pair(MODE_CIRC_CIRC, 0, 0, 0, 0, 2, 3, 4, 0, 0, 2);
        offer_pair(MODE_CIRC_CIRC, 7, -7, 0, 0, 0, 7, -7, 0, 0, 0);
        offer_pair(MODE_CIRC_CIRC, CoordMin, CoordMin, 0, 0, SizeMax,
                   CoordMax, CoordMax, 0, 0, SizeMax);
        offer_pair(MODE_CIRC_CIRC, CoordMin, 0, 0, 0, SizeMax,
                   CoordMax - CoordW'(1), 0, 0, 0, SizeMax);
        // Rectangle then circle: centre inside, corner touch, corner miss,
        // edge touch, edge miss, and a miss found only by the corner distance.
        offer_pair(MODE_RECT_CIRC, 0, 0, 100, 100, SizeMax, 50, 50, 0, 0, 10);
        offer_pair(MODE_RECT_CIRC, 0, 0, 0, 0, 0, 3, 4, 0, 0, 5);
        offer_pair(MODE_RECT_CIRC, 0, 0, 0, 0, 0, 3, 4, 0, 0, 4);
        offer_pair(MODE_RECT_CIRC, 0, 0, 10, 10, 0, 15, 5, 0, 0, 5);
        offer_pair(MODE_RECT_CIRC, 0, 0, 10, 10, 0, 16, 5, 0, 0, 5);
        offer_pair(MODE_RECT_CIRC, 0, 0, 10, 10, 0, 13, 13, 0, 0, 4);
        offer_pair(MODE_RECT_CIRC, CoordMax, CoordMax, SizeMax, SizeMax, 0,
                   CoordMin, CoordMin, 0, 0, SizeMax);
        // Circle then rectangle: the same corner cases with the roles swapped.
        offer_pair(MODE_CIRC_RECT, 3, 4, SizeMax, SizeMax, 5, 0, 0, 0, 0, SizeMax);
        offer_pair(MODE_CIRC_RECT, 13, 13, 0, 0, 4, 0, 0, 10, 10, 0);
        offer_pair(MODE_CIRC_RECT, CoordMax, CoordMax, 0, 0, SizeMax,
                   CoordMin, CoordMin, SizeMax, SizeMax, 0);

        // Random pairs. Most of them are clustered: both shapes sit near a
        // shared random origin, with offsets and sizes on one random scale, so
        // that exact touches, near misses and corner regions turn up at every
        // magnitude. The rest use the full range of every field. The fields
        // a shape does not use always carry full random values.
        for (int n = 0; n < RandomItems; n++) begin
            mode = ModeW'($urandom_range(0, 3));
            if ($urandom_range(0, 4) == 0) begin
                ax = CoordW'($urandom); ay = CoordW'($urandom);
                aw = SizeW'($urandom);  ah = SizeW'($urandom);  ar = SizeW'($urandom);
                bx = CoordW'($urandom); by = CoordW'($urandom);
                bw = SizeW'($urandom);  bh = SizeW'($urandom);  br = SizeW'($urandom);
            end else begin
                span   = 1 << $urandom_range(1, 20);
                base_x = CoordW'($urandom);
                base_y = CoordW'($urandom);
                ax = base_x + CoordW'(jitter(span));
                ay = base_y + CoordW'(jitter(span));
                bx = base_x + CoordW'(jitter(span));
                by = base_y + CoordW'(jitter(span));
                aw = SizeW'($urandom_range(0, span));
                ah = SizeW'($urandom_range(0, span));
                ar = SizeW'($urandom_range(0, span));
                bw = SizeW'($urandom_range(0, span));
                bh = SizeW'($urandom_range(0, span));
                br = SizeW'($urandom_range(0, span));
                if (mode == MODE_CIRC_CIRC || mode == MODE_CIRC_RECT) begin
                    aw = SizeW'($urandom);
                    ah = SizeW'($urandom);
                end else begin
                    ar = SizeW'($urandom);
                end
                if (mode == MODE_CIRC_CIRC || mode == MODE_RECT_CIRC) begin
                    bw = SizeW'($urandom);
                    bh = SizeW'($urandom);
                end else begin
                    br = SizeW'($urandom);
                end
            end
            offer_pair(mode, ax, ay, aw, ah, ar, bx, by, bw, bh, br);
        end

        @(negedge clk);
        s_tvalid <= 1'b0;

        // Drain: wait until every predicted result has come back, then give
        // the pipeline time to show any stray result.
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
